// ===== hdl/mft_pkg.sv =====
// Package for the Manchester frame transmitter: payload structs, bus and mode
// codes, configuration register indexes and reset values, and the phase encoding.
// No dependencies.
`default_nettype none

package mft_pkg;

  // Input item: load a frame byte or a half-bit tick
  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [1:0] bus_state;
  } mft_in_t;

  // Result item, one for every input item
  typedef struct packed {
    logic line_level;
    logic sending;
    logic aborted;
    logic frame_done;
    logic timed_out;
  } mft_out_t;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Bus monitor codes. Code 3 behaves as busy.
  localparam logic [1:0] BUS_IDLE = 2'd0;
  localparam logic [1:0] BUS_BUSY = 2'd1;
  localparam logic [1:0] BUS_COLL = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PREAMBLE = 1'b0;
  localparam logic CFG_RETRY    = 1'b1;

  // Configuration reset values
  localparam logic [7:0] PREAMBLE_RST = 8'h55;
  localparam logic [2:0] RETRY_RST    = 3'd5;

  // Transmit phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_PRE  = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_DATA = 5'b01000,
    PH_WAIT = 5'b10000
  } mft_phase_t;

endpackage

`default_nettype wire

// ===== hdl/mft_tx_engine.sv =====
// Transmit engine: frame buffer, phase sequencer and Manchester coder.
// Advances one step per accepted item. Depends on mft_pkg.
`default_nettype none

module mft_tx_engine #(
  parameter int MAX_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire mft_pkg::mft_in_t  item,
  input  wire logic [7:0]        preamble,
  input  wire logic [2:0]        retry_limit,
  output mft_pkg::mft_out_t      result
);

  localparam int IW = $clog2(MAX_BYTES);
  localparam int CW = $clog2(MAX_BYTES + 1);

  // Frame buffer
  logic [7:0]    mem [MAX_BYTES];
  logic [7:0]    rd_data_r;

  // Sequencer state
  mft_pkg::mft_phase_t phase_r, phase_nxt;
  logic [IW-1:0] byte_index_r, byte_index_nxt;
  logic [2:0]    bit_index_r, bit_index_nxt;
  logic          second_half_r, second_half_nxt;
  logic [2:0]    fail_r, fail_nxt;
  logic          line_r, line_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] frame_len_r, frame_len_nxt;

  // Buffer write and current byte
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    cur_byte;
  logic [7:0]    len_byte;
  logic          level;
  logic          aborted;
  logic          done;
  logic          tout;

  assign len_byte = 8'(frame_len_r);

  // Next state and result for one item
  always_comb begin
    phase_nxt       = phase_r;
    byte_index_nxt  = byte_index_r;
    bit_index_nxt   = bit_index_r;
    second_half_nxt = second_half_r;
    fail_nxt        = fail_r;
    line_nxt        = line_r;
    count_nxt       = count_r;
    frame_len_nxt   = frame_len_r;
    level           = line_r;
    aborted         = 1'b0;
    done            = 1'b0;
    tout            = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = IW'(MAX_BYTES - 1);
    cur_byte        = rd_data_r;
    if (step) begin
      if (item.mode == mft_pkg::MODE_LOAD) begin
        // Store a byte; the last one launches the frame
        if (phase_r == mft_pkg::PH_IDLE) begin
          wr_en = 1'b1;
          if (count_r < CW'(MAX_BYTES)) begin
            wr_addr   = IW'(count_r);
            count_nxt = count_r + CW'(1);
          end
          if (item.last_byte) begin
            frame_len_nxt   = count_nxt;
            count_nxt       = '0;
            fail_nxt        = '0;
            phase_nxt       = mft_pkg::PH_PRE;
            byte_index_nxt  = '0;
            bit_index_nxt   = '0;
            second_half_nxt = 1'b0;
          end
        end
      end else begin
        // Idle line stays high; waiting restarts on an idle bus
        if (phase_r == mft_pkg::PH_IDLE) begin
          line_nxt = 1'b1;
          level    = 1'b1;
        end else if (phase_r == mft_pkg::PH_WAIT) begin
          line_nxt = 1'b1;
          level    = 1'b1;
          if (item.bus_state == mft_pkg::BUS_IDLE) begin
            phase_nxt       = mft_pkg::PH_PRE;
            byte_index_nxt  = '0;
            bit_index_nxt   = '0;
            second_half_nxt = 1'b0;
          end
        end
        if (phase_nxt != mft_pkg::PH_IDLE && phase_nxt != mft_pkg::PH_WAIT) begin
          case (phase_nxt)
            mft_pkg::PH_PRE: cur_byte = preamble;
            mft_pkg::PH_LEN: cur_byte = len_byte;
            default:         cur_byte = rd_data_r;
          endcase
          if (!second_half_nxt) begin
            if (item.bus_state == mft_pkg::BUS_COLL) begin
              // Collision at bit start: abort, then retry or give up
              aborted  = 1'b1;
              line_nxt = 1'b1;
              level    = 1'b1;
              if (fail_r < retry_limit) begin
                fail_nxt  = fail_r + 3'd1;
                phase_nxt = mft_pkg::PH_WAIT;
              end else begin
                tout      = 1'b1;
                phase_nxt = mft_pkg::PH_IDLE;
              end
            end else begin
              // First half: a one goes low, a zero goes high
              line_nxt        = ~cur_byte[~bit_index_nxt];
              level           = line_nxt;
              second_half_nxt = 1'b1;
            end
          end else begin
            // Second half: invert, then advance bit, byte and phase
            line_nxt        = ~line_r;
            level           = line_nxt;
            second_half_nxt = 1'b0;
            if (bit_index_nxt != 3'd7) begin
              bit_index_nxt = bit_index_nxt + 3'd1;
            end else begin
              bit_index_nxt = '0;
              if (phase_nxt == mft_pkg::PH_PRE) begin
                phase_nxt = mft_pkg::PH_LEN;
              end else if (phase_nxt == mft_pkg::PH_LEN) begin
                phase_nxt      = mft_pkg::PH_DATA;
                byte_index_nxt = '0;
              end else if ((CW'(byte_index_nxt) + CW'(1)) < frame_len_r) begin
                byte_index_nxt = byte_index_nxt + IW'(1);
              end else begin
                done      = 1'b1;
                phase_nxt = mft_pkg::PH_IDLE;
                line_nxt  = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  assign result.line_level = level;
  assign result.sending    = (phase_nxt != mft_pkg::PH_IDLE);
  assign result.aborted    = aborted;
  assign result.frame_done = done;
  assign result.timed_out  = tout;

  // Buffer write and prefetch of the byte at the next byte index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item.data_byte;
    end
    rd_data_r <= mem[byte_index_nxt];
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= mft_pkg::PH_IDLE;
      byte_index_r  <= '0;
      bit_index_r   <= '0;
      second_half_r <= 1'b0;
      fail_r        <= '0;
      line_r        <= 1'b1;
      count_r       <= '0;
      frame_len_r   <= '0;
    end else begin
      phase_r       <= phase_nxt;
      byte_index_r  <= byte_index_nxt;
      bit_index_r   <= bit_index_nxt;
      second_half_r <= second_half_nxt;
      fail_r        <= fail_nxt;
      line_r        <= line_nxt;
      count_r       <= count_nxt;
      frame_len_r   <= frame_len_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/manchester_frame_transmitter_core.sv =====
// Top level of the Manchester frame transmitter: handshakes, configuration
// registers and result register. Depends on mft_pkg and mft_tx_engine.
`default_nettype none

// Usage:
//   Input channel (in_valid/in_ready/in_data) carries load items, which store
//   frame bytes, and tick items, each one half-bit time of the line. A load
//   with last_byte set starts the frame: preamble, length, then data, MSB
//   first, Manchester coded over two ticks per bit.
//   Every input transfer yields exactly one result on the out_ channel,
//   through the result register, with the line level and frame status flags.
//   Throughput is one item per clock while the receiver does not stall; each
//   item's step (one buffer read from a prefetch register plus the sequencer
//   update) is combinational between the input handshake and result register.
//   When the receiver stalls, the result register holds its item and in_ready
//   drops; a new item is taken in the same cycle the held result transfers.
//   The user must write configuration (cfg_we/cfg_idx/cfg_wdata) only while
//   idle; the block does not enforce it. Reset (rst_n low, synchronous)
//   returns the line high, the sequencer idle, the byte count to zero and the
//   registers to preamble 0x55, retry limit 5. Buffer contents are not cleared;
//   only written entries are ever sent.
module manchester_frame_transmitter_core #(
  parameter int MAX_BYTES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mft_pkg::mft_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mft_pkg::mft_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic              cfg_idx,
  input  wire logic [7:0]        cfg_wdata
);

  logic                step;
  logic [7:0]          preamble_r;
  logic [2:0]          retry_r;
  mft_pkg::mft_out_t   result;
  mft_pkg::mft_out_t   out_data_r;
  logic                out_valid_r;

  // Take a new item whenever the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_r <= mft_pkg::PREAMBLE_RST;
      retry_r    <= mft_pkg::RETRY_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        mft_pkg::CFG_PREAMBLE: preamble_r <= cfg_wdata;
        mft_pkg::CFG_RETRY:    retry_r    <= cfg_wdata[2:0];
        default:               preamble_r <= preamble_r;
      endcase
    end
  end

  mft_tx_engine #(
    .MAX_BYTES (MAX_BYTES)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_data),
    .preamble    (preamble_r),
    .retry_limit (retry_r),
    .result      (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/mft_checker.sv =====
// Port-level checks for the Manchester frame transmitter, bound to the top.
// Depends on mft_pkg and manchester_frame_transmitter_core.
`default_nettype none

module mft_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire mft_pkg::mft_out_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Input is refused only while a result is stalled
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without a stalled result");

  // An abort drives the line high and never coincides with frame end
  a_abort_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.aborted |-> out_data.line_level && !out_data.frame_done)
    else $error("abort with line low or frame end");

  // Timeout comes only with an abort and ends the frame
  a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.timed_out |-> out_data.aborted && !out_data.sending)
    else $error("timeout without abort or still sending");

  // Frame end leaves the transmitter idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> !out_data.sending)
    else $error("frame end while still sending");

endmodule

bind manchester_frame_transmitter_core mft_checker u_mft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for manchester_frame_transmitter_core: directed and random
// load/tick traffic, an in-bench line predictor and per-field result checks.
// Depends on mft_pkg and the transmitter RTL only.

module tb_top;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int BUF_DEPTH    = 256;
  localparam int MAX_REPORTS  = 20;
  // Bus code 3 has no name in the package; the block treats it as busy
  localparam logic [1:0] BUS_ALT = 2'd3;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  mft_pkg::mft_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  mft_pkg::mft_out_t out_data;
  logic              cfg_we;
  logic              cfg_idx;
  logic [7:0]        cfg_wdata;

  manchester_frame_transmitter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state of the transmitter
  logic [7:0]          preamble_q;
  logic [2:0]          retry_q;
  logic [7:0]          buf_mem [BUF_DEPTH];
  int                  load_count;
  int                  frame_len;
  mft_pkg::mft_phase_t tx_phase;
  int                  byte_pos;
  logic [2:0]          bit_pos;
  logic                half_q;
  logic [2:0]          fail_count;
  logic                line_q;

  mft_pkg::mft_out_t   expected_lines[$];

  int          mismatches;
  int          useful_items;
  int          results_seen;
  int          frames_sent;
  int          aborts_seen;
  int          timeouts_seen;
  int          cfg_writes;
  int unsigned cycle_count;

  // Sender burst state
  int          burst_left;
  bit          gaps_on;

  // Receiver stall pattern
  logic [7:0]  ready_pattern;
  int unsigned stall_step;

  function automatic void restart_frame();
    tx_phase = mft_pkg::PH_PRE;
    byte_pos = 0;
    bit_pos  = 3'd0;
    half_q   = 1'b0;
  endfunction

  // Advance the predictor by one item and return the expected line result
  function automatic mft_pkg::mft_out_t predict_line(mft_pkg::mft_in_t it);
    mft_pkg::mft_out_t r;
    logic [7:0]        cur;
    r = '0;
    if (it.mode == mft_pkg::MODE_LOAD) begin
      if (tx_phase == mft_pkg::PH_IDLE) begin
        buf_mem[8'((load_count < BUF_DEPTH) ? load_count : BUF_DEPTH - 1)] = it.data_byte;
        if (load_count < BUF_DEPTH)
          load_count++;
        if (it.last_byte) begin
          frame_len  = load_count;
          load_count = 0;
          fail_count = 3'd0;
          restart_frame();
        end
      end
      r.line_level = line_q;
    end else if (tx_phase == mft_pkg::PH_IDLE) begin
      line_q       = 1'b1;
      r.line_level = 1'b1;
    end else if (tx_phase == mft_pkg::PH_WAIT) begin
      line_q       = 1'b1;
      r.line_level = 1'b1;
      if (it.bus_state == mft_pkg::BUS_IDLE)
        restart_frame();
    end else begin
      r.line_level = line_q;
    end

    // Tick in a sending phase, possibly just restarted out of the wait
    if (it.mode == mft_pkg::MODE_TICK && tx_phase != mft_pkg::PH_IDLE &&
        tx_phase != mft_pkg::PH_WAIT) begin
      if (!half_q) begin
        if (it.bus_state == mft_pkg::BUS_COLL) begin
          r.aborted    = 1'b1;
          line_q       = 1'b1;
          r.line_level = 1'b1;
          if (fail_count < retry_q) begin
            fail_count++;
            tx_phase = mft_pkg::PH_WAIT;
          end else begin
            r.timed_out = 1'b1;
            tx_phase    = mft_pkg::PH_IDLE;
          end
        end else begin
          case (tx_phase)
            mft_pkg::PH_PRE: cur = preamble_q;
            mft_pkg::PH_LEN: cur = frame_len[7:0];
            default:         cur = buf_mem[8'(byte_pos)];
          endcase
          line_q       = ~cur[3'd7 - bit_pos];
          r.line_level = line_q;
          half_q       = 1'b1;
        end
      end else begin
        line_q       = ~line_q;
        r.line_level = line_q;
        half_q       = 1'b0;
        if (bit_pos != 3'd7) begin
          bit_pos++;
        end else begin
          bit_pos = 3'd0;
          if (tx_phase == mft_pkg::PH_PRE) begin
            tx_phase = mft_pkg::PH_LEN;
          end else if (tx_phase == mft_pkg::PH_LEN) begin
            tx_phase = mft_pkg::PH_DATA;
            byte_pos = 0;
          end else if (byte_pos + 1 < frame_len) begin
            byte_pos++;
          end else begin
            r.frame_done = 1'b1;
            tx_phase     = mft_pkg::PH_IDLE;
            line_q       = 1'b1;
          end
        end
      end
    end
    r.sending = (tx_phase != mft_pkg::PH_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               what, results_seen, want_v, got_v);
  endtask

  // Check results, track configuration writes and predict each input transfer
  always @(posedge clk) begin
    mft_pkg::mft_out_t want;
    if (!rst_n) begin
      preamble_q = mft_pkg::PREAMBLE_RST;
      retry_q    = mft_pkg::RETRY_RST;
      load_count = 0;
      frame_len  = 0;
      tx_phase   = mft_pkg::PH_IDLE;
      byte_pos   = 0;
      bit_pos    = 3'd0;
      half_q     = 1'b0;
      fail_count = 3'd0;
      line_q     = 1'b1;
      expected_lines.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("result with nothing pending", 0, int'(out_data));
        end else begin
          want = expected_lines.pop_front();
          if (out_data.line_level !== want.line_level)
            report_mismatch("line_level", want.line_level, out_data.line_level);
          if (out_data.sending !== want.sending)
            report_mismatch("sending", want.sending, out_data.sending);
          if (out_data.aborted !== want.aborted)
            report_mismatch("aborted", want.aborted, out_data.aborted);
          if (out_data.frame_done !== want.frame_done)
            report_mismatch("frame_done", want.frame_done, out_data.frame_done);
          if (out_data.timed_out !== want.timed_out)
            report_mismatch("timed_out", want.timed_out, out_data.timed_out);
        end
        results_seen++;
        if (out_data.frame_done === 1'b1) frames_sent++;
        if (out_data.aborted === 1'b1) aborts_seen++;
        if (out_data.timed_out === 1'b1) timeouts_seen++;
      end
      if (cfg_we) begin
        cfg_writes++;
        if (cfg_idx == mft_pkg::CFG_PREAMBLE)
          preamble_q = cfg_wdata;
        else
          retry_q = cfg_wdata[2:0];
      end
      if (in_valid && in_ready) begin
        // loads during a frame are dropped by the block
        if (!(in_data.mode == mft_pkg::MODE_LOAD && tx_phase != mft_pkg::PH_IDLE))
          useful_items++;
        expected_lines.push_back(predict_line(in_data));
      end
    end
  end

  // Receiver: stall on a repeating pattern that changes now and then
  always @(negedge clk) begin
    stall_step++;
    if (stall_step % 48 == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern = 8'hFF;
        1:       ready_pattern = 8'hAA;
        default: ready_pattern = 8'($urandom_range(0, 255)) | 8'h01;
      endcase
    end
    out_ready <= ready_pattern[3'(stall_step)];
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles with %0d results pending",
             cycle_count, expected_lines.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Send one item, in bursts with random gaps when gaps_on is set; returns at
  // the falling edge after the transfer with valid still high
  task automatic send_item(input mft_pkg::mft_in_t it);
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 24));
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_byte(input logic [7:0] value, input logic last);
    mft_pkg::mft_in_t it;
    it.mode      = mft_pkg::MODE_LOAD;
    it.data_byte = value;
    it.last_byte = last;
    it.bus_state = 2'($urandom_range(0, 3));
    send_item(it);
  endtask

  task automatic tick(input logic [1:0] bus);
    mft_pkg::mft_in_t it;
    it.mode      = mft_pkg::MODE_TICK;
    it.data_byte = 8'($urandom_range(0, 255));
    it.last_byte = 1'($urandom_range(0, 1));
    it.bus_state = bus;
    send_item(it);
  endtask

  function automatic logic [1:0] pick_quiet_bus();
    case ($urandom_range(0, 2))
      0:       return mft_pkg::BUS_IDLE;
      1:       return mft_pkg::BUS_BUSY;
      default: return BUS_ALT;
    endcase
  endfunction

  // Tick until the frame in flight ends, with collisions at the given percent
  task automatic run_frame(input int coll_pct);
    logic [1:0] bus;
    while (tx_phase != mft_pkg::PH_IDLE) begin
      if ($urandom_range(0, 19) == 0) begin
        load_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        if (tx_phase == mft_pkg::PH_WAIT)
          bus = ($urandom_range(0, 2) == 0) ? mft_pkg::BUS_IDLE : 2'($urandom_range(0, 3));
        else if ($urandom_range(0, 99) < coll_pct)
          bus = mft_pkg::BUS_COLL;
        else
          bus = pick_quiet_bus();
        tick(bus);
      end
    end
  endtask

  // Hold off the sender until every pending result has arrived
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_lines.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    run_frame(0);
    wait_results();
    repeat (2) @(negedge clk);
    cfg_idx   <= idx;
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reset settings: idle ticks and loads, then a two-byte frame
  task automatic test_short_frame();
    gaps_on = 1'b0;
    tick(BUS_ALT);
    tick(mft_pkg::BUS_COLL);
    load_byte(8'h00, 1'b0);
    tick(mft_pkg::BUS_BUSY);
    load_byte(8'hFF, 1'b1);
    tick(BUS_ALT);
    load_byte(8'h81, 1'b1);
    run_frame(0);
  endtask

  task automatic test_preamble_extremes();
    gaps_on = 1'b1;
    write_reg(mft_pkg::CFG_PREAMBLE, 8'hFF);
    load_byte(8'hA5, 1'b1);
    run_frame(0);
    write_reg(mft_pkg::CFG_PREAMBLE, 8'h00);
    load_byte(8'h5A, 1'b1);
    run_frame(0);
  endtask

  task automatic test_collisions();
    gaps_on = 1'b1;
    // no retries: the first collision times out
    write_reg(mft_pkg::CFG_RETRY, 8'd0);
    load_byte(8'hC3, 1'b1);
    tick(mft_pkg::BUS_COLL);
    // most retries, collide at every bit start
    write_reg(mft_pkg::CFG_RETRY, 8'd7);
    load_byte(8'h3C, 1'b0);
    load_byte(8'h96, 1'b1);
    run_frame(100);
    // one retry: wait out a busy bus, restart, collide again
    write_reg(mft_pkg::CFG_RETRY, 8'd1);
    load_byte(8'h69, 1'b1);
    tick(mft_pkg::BUS_COLL);
    tick(mft_pkg::BUS_BUSY);
    tick(BUS_ALT);
    tick(mft_pkg::BUS_IDLE);
    tick(mft_pkg::BUS_COLL);
    tick(mft_pkg::BUS_COLL);
    // failure count starts over with a new frame
    load_byte(8'hF0, 1'b1);
    tick(mft_pkg::BUS_COLL);
    run_frame(0);
    wait_results();
  endtask

  // Overfill the buffer so the count saturates and the length byte wraps to 0;
  // send preamble, length and two data bytes, then end the frame by a collision
  task automatic test_full_buffer();
    gaps_on = 1'b1;
    write_reg(mft_pkg::CFG_PREAMBLE, mft_pkg::PREAMBLE_RST);
    write_reg(mft_pkg::CFG_RETRY, 8'd0);
    for (int i = 0; i < BUF_DEPTH + 2; i++)
      load_byte(8'($urandom_range(0, 255)), i == BUF_DEPTH + 1);
    repeat (64) tick(pick_quiet_bus());
    tick(mft_pkg::BUS_COLL);
    run_frame(0);
    write_reg(mft_pkg::CFG_RETRY, 8'(mft_pkg::RETRY_RST));
  endtask

  task automatic test_random_traffic(input int target);
    int                start_count;
    int                sel;
    int                len;
    int                coll_pct;
    mft_pkg::mft_in_t  it;
    logic [7:0]        pre;
    start_count = useful_items;
    while (useful_items - start_count < target) begin
      sel     = int'($urandom_range(0, 99));
      gaps_on = ($urandom_range(0, 3) != 0);
      if (sel < 6) begin
        case ($urandom_range(0, 3))
          0:       pre = 8'h00;
          1:       pre = 8'hFF;
          default: pre = 8'($urandom_range(0, 255));
        endcase
        write_reg(mft_pkg::CFG_PREAMBLE, pre);
        write_reg(mft_pkg::CFG_RETRY, 8'($urandom_range(0, 7)));
      end else if (sel < 20) begin
        // noise: any field values
        repeat ($urandom_range(1, 6)) begin
          it.mode      = 1'($urandom_range(0, 1));
          it.data_byte = 8'($urandom_range(0, 255));
          it.last_byte = 1'($urandom_range(0, 1));
          it.bus_state = 2'($urandom_range(0, 3));
          send_item(it);
        end
      end else begin
        run_frame(5);
        len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(7, 40))
                                          : int'($urandom_range(1, 6));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 7) == 0)
            tick(2'($urandom_range(0, 3)));
          load_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
        case ($urandom_range(0, 3))
          0, 1:    coll_pct = 0;
          2:       coll_pct = 3;
          default: coll_pct = 15;
        endcase
        run_frame(coll_pct);
        if ($urandom_range(0, 9) == 0)
          wait_results();
      end
    end
    run_frame(0);
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b1;
    cfg_we        = 1'b0;
    cfg_idx       = mft_pkg::CFG_PREAMBLE;
    cfg_wdata     = 8'h00;
    ready_pattern = 8'hFF;
    stall_step    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    gaps_on       = 1'b0;
    mismatches    = 0;
    useful_items  = 0;
    results_seen  = 0;
    frames_sent   = 0;
    aborts_seen   = 0;
    timeouts_seen = 0;
    cfg_writes    = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_short_frame();
    test_preamble_extremes();
    test_collisions();
    test_full_buffer();
    test_random_traffic(RANDOM_ITEMS);

    wait_results();
    repeat (4) @(negedge clk);

    $display("Checked %0d results from %0d effective items, %0d register writes",
             results_seen, useful_items, cfg_writes);
    $display("Saw %0d frames completed, %0d collision aborts, %0d retry timeouts",
             frames_sent, aborts_seen, timeouts_seen);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
